// File: hdl/dswt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dswt_pkg
// Shared types and constants of the data stack with its top-of-stack window.
// ----------------------------------------------------------------------------
package dswt_pkg;

	localparam int DEPTH  = 64;
	localparam int WIN    = 4;
	localparam int DATA_W = 32;
	localparam int REQ_W  = 2;
	localparam int SEL_W  = 3;
	localparam int PTR_W  = $clog2(DEPTH + 1);
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int WIN_W  = $clog2(WIN);
	localparam int YCNT_W = $clog2(WIN + 1);

	localparam logic [PTR_W-1:0] PTR_DEPTH = PTR_W'(DEPTH);

	localparam int USER_W      = REQ_W + SEL_W;
	localparam int RES_W       = DATA_W * (WIN + 1) + PTR_W + 2;
	localparam int OUT_TDATA_W = ((RES_W + 7) / 8) * 8;
	localparam int DEPTH_LSB   = DATA_W * (WIN + 1);
	localparam int OVF_BIT     = DEPTH_LSB + PTR_W;
	localparam int UNF_BIT     = OVF_BIT + 1;

	localparam logic [REQ_W-1:0] REQ_READ  = 2'd0;
	localparam logic [REQ_W-1:0] REQ_WRITE = 2'd1;
	localparam logic [REQ_W-1:0] REQ_STACK = 2'd2;

	localparam logic [SEL_W-1:0] OP_POP       = 3'd0;
	localparam logic [SEL_W-1:0] OP_PUSH      = 3'd1;
	localparam logic [SEL_W-1:0] OP_PUSH_SYNC = 3'd2;
	localparam logic [SEL_W-1:0] OP_POP_SYNC  = 3'd3;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SYNC,
		ST_DONE
	} dswt_state_t;

	typedef struct packed {
		logic              en;
		logic              we;
		logic [ADDR_W-1:0] addr;
		logic [DATA_W-1:0] wdata;
	} dswt_ram_req_t;

	typedef struct packed {
		logic                      unf;
		logic                      ovf;
		logic [PTR_W-1:0]          depth;
		logic [WIN-1:0][DATA_W-1:0] win;
		logic [DATA_W-1:0]         rd;
	} dswt_result_t;

endpackage
`default_nettype wire

// File: hdl/data_stack_with_top_window.sv
`default_nettype none
// ----------------------------------------------------------------------------
// data_stack_with_top_window
// Data stack of a zero-operand stack machine with a four-word top-of-stack
// window, one result word per request word.
// ----------------------------------------------------------------------------
// One request word passes an accept state, an execute state (pointer update,
// stack write or read at the pointer), then up to four window reads through
// the single port of the stack memory with capture of the last read data, and
// a done state that waits for the output register to be free and loads it.
// A new request is taken while the previous result still waits in the output
// register. The stack memory reads as zero after reset through per-entry valid
// flags, so no clearing pass is needed.
module data_stack_with_top_window (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [dswt_pkg::DATA_W-1:0]         s_axis_tdata,  // write_data
	input  logic [dswt_pkg::USER_W-1:0]         s_axis_tuser,  // req_type, slot_or_op
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// read_data, window_0, window_1, window_2, window_3, depth, overflow, underflow
	output logic [dswt_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

	dswt_pkg::dswt_result_t  result;
	dswt_pkg::dswt_ram_req_t ram_req;
	logic [dswt_pkg::DATA_W-1:0] ram_rdata;
	logic                        done;
	logic                        out_free;
	logic                        m_valid_q;
	logic [dswt_pkg::OUT_TDATA_W-1:0] m_data_q;

	assign out_free = !m_valid_q || m_axis_tready;

	dswt_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_valid    (s_axis_tvalid),
		.s_ready    (s_axis_tready),
		.req_type   (s_axis_tuser[dswt_pkg::REQ_W-1:0]),
		.slot_or_op (s_axis_tuser[dswt_pkg::USER_W-1:dswt_pkg::REQ_W]),
		.write_data (s_axis_tdata),
		.out_free   (out_free),
		.done       (done),
		.result     (result),
		.ram_req    (ram_req),
		.ram_rdata  (ram_rdata)
	);

	dswt_ram #(
		.WIDTH (dswt_pkg::DATA_W),
		.DEPTH (dswt_pkg::DEPTH)
	) u_ram (
		.clk   (clk),
		.en    (ram_req.en),
		.we    (ram_req.we),
		.addr  (ram_req.addr),
		.wdata (ram_req.wdata),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (done) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			m_data_q <= {{(dswt_pkg::OUT_TDATA_W - dswt_pkg::RES_W){1'b0}}, result};
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

	// overflow only with the pointer held at full depth
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tdata[dswt_pkg::OVF_BIT])
		|-> (m_axis_tdata[dswt_pkg::DEPTH_LSB +: dswt_pkg::PTR_W] == dswt_pkg::PTR_DEPTH))
		else $error("overflow flagged below full depth");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !(m_axis_tdata[dswt_pkg::OVF_BIT] && m_axis_tdata[dswt_pkg::UNF_BIT]))
		else $error("overflow and underflow in one word");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid
		|-> (m_axis_tdata[dswt_pkg::DEPTH_LSB +: dswt_pkg::PTR_W] <= dswt_pkg::PTR_DEPTH))
		else $error("stack pointer beyond depth");

	assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
		else $error("request taken while another is in progress");

	assert property (@(posedge clk) disable iff (!arst_n)
		done |=> m_axis_tvalid)
		else $error("finished result not presented");

endmodule
`default_nettype wire

// File: hdl/dswt_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dswt_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module dswt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule
`default_nettype wire

// File: hdl/dswt_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dswt_ctrl
// Request sequencer: pointer update, stack write and the window sync reads,
// all through the one port of the stack memory.
// ----------------------------------------------------------------------------
module dswt_ctrl (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_valid,
	output logic                           s_ready,
	input  logic [dswt_pkg::REQ_W-1:0]     req_type,
	input  logic [dswt_pkg::SEL_W-1:0]     slot_or_op,
	input  logic [dswt_pkg::DATA_W-1:0]    write_data,
	input  logic                           out_free,
	output logic                           done,
	output dswt_pkg::dswt_result_t         result,
	output dswt_pkg::dswt_ram_req_t        ram_req,
	input  logic [dswt_pkg::DATA_W-1:0]    ram_rdata
);

	dswt_pkg::dswt_state_t state_q, state_d;

	logic [dswt_pkg::REQ_W-1:0]  req_q;
	logic [dswt_pkg::SEL_W-1:0]  sel_q;
	logic [dswt_pkg::DATA_W-1:0] data_q;
	logic [dswt_pkg::PTR_W-1:0]  sp_q;
	logic [dswt_pkg::DEPTH-1:0]  vld_q;
	logic [dswt_pkg::DATA_W-1:0] win_q [dswt_pkg::WIN];
	logic [dswt_pkg::DATA_W-1:0] rd_q;
	logic                        ovf_q;
	logic                        unf_q;
	logic [dswt_pkg::YCNT_W-1:0] y_q;

	logic                        cap_v_s1;
	logic                        cap_rd_s1;
	logic                        vld_rd_s1;
	logic [dswt_pkg::WIN_W-1:0]  cap_idx_s1;
	logic [dswt_pkg::DATA_W-1:0] cap_word;

	logic                        slot_ok;
	logic                        is_rd;
	logic                        is_wr;
	logic                        is_op;
	logic                        op_push;
	logic                        op_pop;
	logic                        sync_en;
	logic                        wr_ok;
	logic                        rd_ok;
	logic                        issue;
	logic                        rd_issue;
	logic [dswt_pkg::PTR_W-1:0]  sel_ext;
	logic [dswt_pkg::PTR_W-1:0]  y_ext;
	logic [dswt_pkg::PTR_W-1:0]  wr_idx;
	logic [dswt_pkg::PTR_W-1:0]  sync_idx;

	// request decode
	always_comb begin
		op_push = 1'b0;
		op_pop  = 1'b0;
		unique case (sel_q) inside
			dswt_pkg::OP_PUSH, dswt_pkg::OP_PUSH_SYNC: op_push = 1'b1;
			dswt_pkg::OP_POP, dswt_pkg::OP_POP_SYNC:   op_pop  = 1'b1;
			default: ;
		endcase
	end

	assign slot_ok  = sel_q < dswt_pkg::SEL_W'(dswt_pkg::WIN);
	assign is_rd    = (req_q == dswt_pkg::REQ_READ) && slot_ok;
	assign is_wr    = (req_q == dswt_pkg::REQ_WRITE) && slot_ok;
	assign is_op    = req_q == dswt_pkg::REQ_STACK;
	assign sync_en  = is_rd || is_wr || (is_op && (sel_q >= dswt_pkg::OP_PUSH_SYNC));
	assign sel_ext  = dswt_pkg::PTR_W'(sel_q);
	assign y_ext    = dswt_pkg::PTR_W'(y_q);
	assign wr_ok    = sp_q > sel_ext;
	assign wr_idx   = sp_q - sel_ext - dswt_pkg::PTR_W'(1);
	assign rd_ok    = sp_q < dswt_pkg::PTR_DEPTH;
	assign sync_idx = sp_q - y_ext - dswt_pkg::PTR_W'(1);
	assign issue    = (state_q == dswt_pkg::ST_SYNC) && sync_en
		&& (y_q < dswt_pkg::YCNT_W'(dswt_pkg::WIN)) && (y_ext < sp_q);
	assign rd_issue = (state_q == dswt_pkg::ST_EXEC) && is_rd && rd_ok;
	assign cap_word = vld_rd_s1 ? ram_rdata : '0;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			dswt_pkg::ST_IDLE: if (s_valid) state_d = dswt_pkg::ST_EXEC;
			dswt_pkg::ST_EXEC: state_d = dswt_pkg::ST_SYNC;
			dswt_pkg::ST_SYNC: if (!issue) state_d = dswt_pkg::ST_DONE;
			dswt_pkg::ST_DONE: if (out_free) state_d = dswt_pkg::ST_IDLE;
			default: state_d = dswt_pkg::ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		s_ready = 1'b0;
		done    = 1'b0;
		ram_req = '0;
		unique case (state_q)
			dswt_pkg::ST_IDLE: s_ready = 1'b1;
			dswt_pkg::ST_EXEC: begin
				if (rd_issue) begin
					ram_req.en   = 1'b1;
					ram_req.addr = sp_q[dswt_pkg::ADDR_W-1:0];
				end else if (is_wr && wr_ok) begin
					ram_req.en    = 1'b1;
					ram_req.we    = 1'b1;
					ram_req.addr  = wr_idx[dswt_pkg::ADDR_W-1:0];
					ram_req.wdata = data_q;
				end
			end
			dswt_pkg::ST_SYNC: begin
				if (issue) begin
					ram_req.en   = 1'b1;
					ram_req.addr = sync_idx[dswt_pkg::ADDR_W-1:0];
				end
			end
			dswt_pkg::ST_DONE: done = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= dswt_pkg::ST_IDLE;
			sp_q     <= '0;
			vld_q    <= '0;
			y_q      <= '0;
			cap_v_s1 <= 1'b0;
			for (int i = 0; i < dswt_pkg::WIN; i++) begin
				win_q[i] <= '0;
			end
		end else begin
			state_q  <= state_d;
			cap_v_s1 <= ram_req.en && !ram_req.we;
			if (state_q == dswt_pkg::ST_EXEC) begin
				y_q <= '0;
				if (is_op && op_push && (sp_q != dswt_pkg::PTR_DEPTH)) begin
					sp_q <= sp_q + dswt_pkg::PTR_W'(1);
				end else if (is_op && op_pop && (sp_q != '0)) begin
					sp_q <= sp_q - dswt_pkg::PTR_W'(1);
				end
			end else if (issue) begin
				y_q <= y_q + dswt_pkg::YCNT_W'(1);
			end
			if (ram_req.en && ram_req.we) begin
				vld_q[ram_req.addr] <= 1'b1;
			end
			if (cap_v_s1 && !cap_rd_s1) begin
				win_q[cap_idx_s1] <= cap_word;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_valid && s_ready) begin
			req_q  <= req_type;
			sel_q  <= slot_or_op;
			data_q <= write_data;
		end
		cap_rd_s1  <= rd_issue;
		cap_idx_s1 <= y_q[dswt_pkg::WIN_W-1:0];
		vld_rd_s1  <= vld_q[ram_req.addr];
		if (state_q == dswt_pkg::ST_EXEC) begin
			rd_q  <= '0;
			ovf_q <= is_op && op_push && (sp_q == dswt_pkg::PTR_DEPTH);
			unf_q <= (is_op && op_pop && (sp_q == '0)) || (is_wr && !wr_ok);
		end else if (cap_v_s1 && cap_rd_s1) begin
			rd_q <= cap_word;
		end
	end

	always_comb begin
		result.rd    = rd_q;
		result.depth = sp_q;
		result.ovf   = ovf_q;
		result.unf   = unf_q;
		for (int i = 0; i < dswt_pkg::WIN; i++) begin
			result.win[i] = win_q[i];
		end
	end

endmodule
`default_nettype wire

// File: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Bench for the data stack with its four-word top-of-stack window. Requests
// go in on the slave stream and every accepted word is run through a local
// model of the stack. The expected result words are queued in order and
// compared field by field with each word taken from the master stream. A
// short table of directed requests comes first. It is followed by random
// phases that fill, drain or churn the stack. Both sides idle at random, with
// two long calm stretches, two long output stalls and two full drains.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [dswt_pkg::REQ_W-1:0] REQ_NOP = 2'd3;
	localparam logic [dswt_pkg::SEL_W-1:0] OP_SYNC = 3'd4;
	localparam int ITEMS = 1200;

	typedef struct {
		logic [dswt_pkg::REQ_W-1:0]  kind;
		logic [dswt_pkg::SEL_W-1:0]  sel;
		logic [dswt_pkg::DATA_W-1:0] wdata;
		bit                          typed;
		dswt_pkg::dswt_result_t      res;
	} dir_row_t;

	logic                             clk;
	logic                             arst_n        = 1'b0;
	logic                             s_axis_tvalid = 1'b0;
	logic                             s_axis_tready;
	logic [dswt_pkg::DATA_W-1:0]      s_axis_tdata  = '0;  // write_data
	logic [dswt_pkg::USER_W-1:0]      s_axis_tuser  = '0;  // req_type, slot_or_op
	logic                             m_axis_tvalid;
	logic                             m_axis_tready = 1'b0;
	// read_data, window_0, window_1, window_2, window_3, depth, overflow, underflow
	logic [dswt_pkg::OUT_TDATA_W-1:0] m_axis_tdata;

	logic [dswt_pkg::DATA_W-1:0] stk_mem [dswt_pkg::DEPTH];
	logic [dswt_pkg::DATA_W-1:0] win_regs [dswt_pkg::WIN];
	logic [dswt_pkg::PTR_W-1:0]  stk_ptr;

	dswt_pkg::dswt_result_t expected_q [$];
	int           errors   = 0;
	bit           calm     = 1'b0;
	int           hold_req = 0;

	data_stack_with_top_window dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#3_000_000;
		$display("FAIL data_stack_with_top_window");
		$finish;
	end

	// copy up to four entries from the top, only as many as the stack holds
	function automatic void sync_top();
		for (int y = 0; y < dswt_pkg::WIN && y < stk_ptr; y++) begin
			win_regs[y] = stk_mem[stk_ptr - y - 1];
		end
	endfunction

	function automatic dswt_pkg::dswt_result_t predict_request(
			logic [dswt_pkg::REQ_W-1:0] kind, logic [dswt_pkg::SEL_W-1:0] sel,
			logic [dswt_pkg::DATA_W-1:0] wdata);
		dswt_pkg::dswt_result_t r;
		r = '0;
		case (kind)
			dswt_pkg::REQ_READ: begin
				if (sel < dswt_pkg::WIN) begin
					if (stk_ptr < dswt_pkg::PTR_DEPTH)
						r.rd = stk_mem[stk_ptr];
					sync_top();
				end
			end
			dswt_pkg::REQ_WRITE: begin
				if (sel < dswt_pkg::WIN) begin
					if (stk_ptr >= sel + 1)
						stk_mem[stk_ptr - sel - 1] = wdata;
					else
						r.unf = 1'b1;
					sync_top();
				end
			end
			dswt_pkg::REQ_STACK: begin
				if (sel == dswt_pkg::OP_PUSH || sel == dswt_pkg::OP_PUSH_SYNC) begin
					if (stk_ptr == dswt_pkg::PTR_DEPTH)
						r.ovf = 1'b1;
					else
						stk_ptr++;
				end else if (sel == dswt_pkg::OP_POP || sel == dswt_pkg::OP_POP_SYNC) begin
					if (stk_ptr == 0)
						r.unf = 1'b1;
					else
						stk_ptr--;
				end
				if (sel >= dswt_pkg::OP_PUSH_SYNC)
					sync_top();
			end
			default: begin
			end
		endcase
		for (int k = 0; k < dswt_pkg::WIN; k++)
			r.win[k] = win_regs[k];
		r.depth = stk_ptr;
		return r;
	endfunction

	function automatic dir_row_t mk_row(logic [dswt_pkg::REQ_W-1:0] kind,
			logic [dswt_pkg::SEL_W-1:0] sel, logic [dswt_pkg::DATA_W-1:0] wdata,
			bit typed = 1'b0, logic [dswt_pkg::PTR_W-1:0] dep = '0,
			logic ovf = 1'b0, logic unf = 1'b0);
		dir_row_t row;
		row.kind  = kind;
		row.sel   = sel;
		row.wdata = wdata;
		row.typed = typed;
		row.res   = '0;
		row.res.depth = dep;
		row.res.ovf   = ovf;
		row.res.unf   = unf;
		return row;
	endfunction

	function automatic logic [dswt_pkg::DATA_W-1:0] pick_word();
		case ($urandom_range(0, 7))
			0: return 32'h0000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'h8000_0000;
			3: return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	task automatic send_word(logic [dswt_pkg::REQ_W-1:0] kind,
			logic [dswt_pkg::SEL_W-1:0] sel, logic [dswt_pkg::DATA_W-1:0] wdata,
			bit typed = 1'b0, dswt_pkg::dswt_result_t typed_res = '0);
		dswt_pkg::dswt_result_t pred;
		while (!calm && $urandom_range(99) < 28) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= {sel, kind};
		s_axis_tdata  <= wdata;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		pred = predict_request(kind, sel, wdata);
		expected_q.push_back(typed ? typed_res : pred);
	endtask

	// bias 0 churns, 1 fills the stack, 2 drains it
	task automatic make_request(int bias, output logic [dswt_pkg::REQ_W-1:0] kind,
			output logic [dswt_pkg::SEL_W-1:0] sel,
			output logic [dswt_pkg::DATA_W-1:0] wdata);
		int r;
		int o;
		int stack_pct;
		r = $urandom_range(99);
		o = $urandom_range(99);
		stack_pct = (bias == 0) ? 40 : 65;
		wdata = pick_word();
		if (r < stack_pct) begin
			kind = dswt_pkg::REQ_STACK;
			if (bias == 1) begin
				if (o < 50)
					sel = dswt_pkg::OP_PUSH;
				else if (o < 90)
					sel = dswt_pkg::OP_PUSH_SYNC;
				else if (o < 95)
					sel = dswt_pkg::OP_POP_SYNC;
				else
					sel = dswt_pkg::SEL_W'($urandom_range(4, 7));
			end else if (bias == 2) begin
				if (o < 50)
					sel = dswt_pkg::OP_POP;
				else if (o < 90)
					sel = dswt_pkg::OP_POP_SYNC;
				else if (o < 95)
					sel = dswt_pkg::OP_PUSH;
				else
					sel = dswt_pkg::SEL_W'($urandom_range(4, 7));
			end else begin
				sel = dswt_pkg::SEL_W'($urandom_range(0, 7));
			end
		end else if (r < stack_pct + 20) begin
			kind = dswt_pkg::REQ_WRITE;
			sel  = dswt_pkg::SEL_W'($urandom_range(0, dswt_pkg::WIN - 1));
		end else if (r < 92) begin
			kind = dswt_pkg::REQ_READ;
			sel  = dswt_pkg::SEL_W'($urandom_range(0, dswt_pkg::WIN - 1));
		end else begin
			kind = (o < 40) ? REQ_NOP : dswt_pkg::REQ_W'($urandom_range(0, 1));
			sel  = dswt_pkg::SEL_W'($urandom_range(4, 7));
		end
	endtask

	task automatic cmp_field(string nm, logic [dswt_pkg::DATA_W-1:0] want,
			logic [dswt_pkg::DATA_W-1:0] got);
		if (got !== want) begin
			$display("%0t ns: %s mismatch, expected %h actual %h", $time, nm, want, got);
			errors++;
		end
	endtask

	// output side: check each accepted word, stall at random or on request
	initial begin
		int hold_left;
		dswt_pkg::dswt_result_t got;
		dswt_pkg::dswt_result_t want;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready) begin
				got = dswt_pkg::dswt_result_t'(m_axis_tdata[dswt_pkg::RES_W-1:0]);
				if (expected_q.size() == 0) begin
					$display("%0t ns: unexpected word, expected none actual %h",
						$time, got);
					errors++;
				end else begin
					want = expected_q.pop_front();
					cmp_field("read_data", want.rd, got.rd);
					for (int k = 0; k < dswt_pkg::WIN; k++)
						cmp_field($sformatf("window_%0d", k), want.win[k], got.win[k]);
					cmp_field("depth", dswt_pkg::DATA_W'(want.depth),
						dswt_pkg::DATA_W'(got.depth));
					cmp_field("overflow", dswt_pkg::DATA_W'(want.ovf),
						dswt_pkg::DATA_W'(got.ovf));
					cmp_field("underflow", dswt_pkg::DATA_W'(want.unf),
						dswt_pkg::DATA_W'(got.unf));
				end
			end
			if (hold_req > 0) begin
				hold_left = hold_req;
				hold_req  = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= calm || ($urandom_range(99) >= 28);
			end
		end
	end

	initial begin
		dir_row_t                    dir_rows [$];
		logic [dswt_pkg::REQ_W-1:0]  kind;
		logic [dswt_pkg::SEL_W-1:0]  sel;
		logic [dswt_pkg::DATA_W-1:0] wdata;
		int sent;
		int phase;
		int phase_len;
		int bias;

		foreach (stk_mem[i])
			stk_mem[i] = '0;
		foreach (win_regs[i])
			win_regs[i] = '0;
		stk_ptr = '0;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		dir_rows.push_back(mk_row(dswt_pkg::REQ_READ, 3'd0, 32'h0, 1'b1, 7'd0));
		dir_rows.push_back(mk_row(dswt_pkg::REQ_STACK, dswt_pkg::OP_POP, 32'h0,
			1'b1, 7'd0, 1'b0, 1'b1));
		dir_rows.push_back(mk_row(dswt_pkg::REQ_STACK, dswt_pkg::OP_POP_SYNC, 32'h0,
			1'b1, 7'd0, 1'b0, 1'b1));
		dir_rows.push_back(mk_row(dswt_pkg::REQ_WRITE, 3'd0, 32'h7FFF_FFFF,
			1'b1, 7'd0, 1'b0, 1'b1));
		dir_rows.push_back(mk_row(REQ_NOP, 3'd7, 32'hFFFF_FFFF, 1'b1, 7'd0));
		dir_rows.push_back(mk_row(dswt_pkg::REQ_STACK, dswt_pkg::OP_PUSH, 32'h0,
			1'b1, 7'd1));
		dir_rows.push_back(mk_row(dswt_pkg::REQ_WRITE, 3'd0, 32'h7FFF_FFFF));
		dir_rows.push_back(mk_row(dswt_pkg::REQ_STACK, dswt_pkg::OP_PUSH_SYNC, 32'h0));
		dir_rows.push_back(mk_row(dswt_pkg::REQ_WRITE, 3'd1, 32'h8000_0000));
		dir_rows.push_back(mk_row(dswt_pkg::REQ_WRITE, 3'd3, 32'h1234_5678));
		dir_rows.push_back(mk_row(dswt_pkg::REQ_WRITE, 3'd2, 32'hFFFF_FFFF));
		dir_rows.push_back(mk_row(dswt_pkg::REQ_STACK, dswt_pkg::OP_PUSH_SYNC, 32'h0));
		dir_rows.push_back(mk_row(dswt_pkg::REQ_STACK, dswt_pkg::OP_PUSH_SYNC, 32'h0));
		dir_rows.push_back(mk_row(dswt_pkg::REQ_WRITE, 3'd3, 32'hFFFF_FFFF));
		dir_rows.push_back(mk_row(dswt_pkg::REQ_WRITE, 3'd0, 32'h0000_0001));
		dir_rows.push_back(mk_row(dswt_pkg::REQ_READ, 3'd0, 32'h0));
		dir_rows.push_back(mk_row(dswt_pkg::REQ_READ, 3'd6, 32'h0));
		dir_rows.push_back(mk_row(dswt_pkg::REQ_WRITE, 3'd4, 32'hA5A5_A5A5));
		dir_rows.push_back(mk_row(dswt_pkg::REQ_STACK, 3'd5, 32'h0));
		dir_rows.push_back(mk_row(dswt_pkg::REQ_STACK, dswt_pkg::OP_POP_SYNC, 32'h0));
		dir_rows.push_back(mk_row(dswt_pkg::REQ_STACK, dswt_pkg::OP_POP, 32'h0));
		dir_rows.push_back(mk_row(dswt_pkg::REQ_STACK, 3'd7, 32'h0));
		dir_rows.push_back(mk_row(dswt_pkg::REQ_READ, 3'd3, 32'h0));
		dir_rows.push_back(mk_row(dswt_pkg::REQ_STACK, OP_SYNC, 32'h0));

		foreach (dir_rows[i])
			send_word(dir_rows[i].kind, dir_rows[i].sel, dir_rows[i].wdata,
				dir_rows[i].typed, dir_rows[i].res);
		sent = dir_rows.size();

		// long output stall while requests keep coming
		calm = 1'b1;
		hold_req = 300;
		repeat (12) begin
			make_request(0, kind, sel, wdata);
			send_word(kind, sel, wdata);
			sent++;
		end
		calm = 1'b0;

		s_axis_tvalid <= 1'b0;
		while (expected_q.size() != 0)
			@(posedge clk);

		phase = 0;
		while (sent < ITEMS) begin
			phase_len = $urandom_range(60, 160);
			bias = (phase < 2) ? 1 : $urandom_range(0, 2);
			calm = (phase == 3);
			if (phase == 6)
				hold_req = $urandom_range(100, 250);
			for (int n = 0; n < phase_len && sent < ITEMS; n++) begin
				make_request(bias, kind, sel, wdata);
				send_word(kind, sel, wdata);
				sent++;
			end
			phase++;
		end
		calm = 1'b0;

		s_axis_tvalid <= 1'b0;
		while (expected_q.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);

		if (errors == 0 && expected_q.size() == 0) begin
			$display("PASS data_stack_with_top_window");
		end else begin
			$display("FAIL data_stack_with_top_window");
		end
		$finish;
	end

endmodule

// File: filelist.f
hdl/dswt_pkg.sv
hdl/dswt_ram.sv
hdl/dswt_ctrl.sv
hdl/data_stack_with_top_window.sv
bench/tb_top.sv
